FILE: rtl/core/mwcs_pkg.sv
package mwcs_pkg;
   localparam int TEXT_DEPTH  = 1024;
   localparam int PATTERN_MAX = 256;
   localparam int SYM_W  = 8;
   localparam int NSYM   = 256;
   localparam int ADDR_W = $clog2(TEXT_DEPTH);
   localparam int POS_W  = $clog2(TEXT_DEPTH + 1);
   localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
   localparam int NEED_W = PLEN_W;
   localparam int WCNT_W = POS_W;
   localparam int DIST_W = $clog2(NSYM + 1);
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic [1:0] STATUS_FOUND    = 2'd0;
   localparam logic [1:0] STATUS_NONE     = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic OP_PATTERN = 1'b0;
   localparam logic OP_TEXT    = 1'b1;

   // one classified command from front to back
   typedef struct packed {
      logic             op;
      logic [SYM_W-1:0] symbol;
      logic             last;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PAT_RD, ST_PAT_WR, ST_TXT_RD, ST_TXT_WR, ST_LOOP,
      ST_SHR_RD, ST_SHR_WR, ST_REPORT, ST_CLEAR
   } state_type;
endpackage

FILE: rtl/core/min_window_cover_search.sv
// Shortest window of a text stream that covers a pattern.
// Input channel req_: operation 0 adds a pattern byte, 1 streams a text byte;
// last marks the final text byte of a job. Output channel rsp_: one item per
// job with status, window_start and window_length.
// A four-entry queue parts the input side from the sequencer, so req_stall
// rises only when the queue is full.
// A pattern byte takes a table read and write; a text byte takes a table read,
// a text and count write and a cover check, plus a text read and a count-table
// read-modify-write (single write port) per left-edge advance. Each byte ends
// before the next is taken; the last text byte adds a report and a clearing pass.
// Reset: a clearing pass of the count tables runs first; items are
// queued meanwhile. The result item is held while rsp_stall is high; the
// clearing pass waits for it only to be loaded, not taken.
module min_window_cover_search import mwcs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [ADDR_W-1:0] rsp_window_start,
   output logic [POS_W-1:0]  rsp_window_length
);
   logic    q_valid, q_take;
   cmd_type q_cmd;

   mwcs_front u_front (.clock, .reset, .req_valid, .req_stall, .req_operation,
      .req_symbol, .req_last, .q_valid, .q_cmd, .q_take);
   mwcs_back u_back (.clock, .reset, .q_valid, .q_cmd, .q_take, .rsp_valid,
      .rsp_stall, .rsp_status, .rsp_window_start, .rsp_window_length);
endmodule

FILE: rtl/core/mwcs_ram.sv
module mwcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: rtl/core/mwcs_front.sv
module mwcs_front import mwcs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_operation,
   input  logic [SYM_W-1:0] req_symbol,
   input  logic             req_last,
   output logic             q_valid,
   output cmd_type          q_cmd,
   input  logic             q_take
);
   cmd_type           buf_ff [QDEPTH];
   logic [QPTR_W-1:0] wp_ff, rp_ff;
   logic [QPTR_W:0]   cnt_ff;
   logic              push;
   cmd_type           cin;

   assign req_stall = (cnt_ff == (QPTR_W+1)'(QDEPTH)) ? 1'b1 : 1'b0;
   assign push      = req_valid & ~req_stall;
   assign q_valid   = cnt_ff != '0;
   assign q_cmd     = buf_ff[rp_ff];

   // classify: last only matters on text bytes
   always_comb begin
      cin.op     = req_operation;
      cin.symbol = req_symbol;
      cin.last   = (req_operation == OP_TEXT) & req_last;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wp_ff] <= cin;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (q_take) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, q_take};
      end
   end

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid) else $error("queue underflow");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR_W+1)'(QDEPTH)) else $error("queue count out of range");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == (QPTR_W+1)'(QDEPTH)) |-> req_stall) else $error("full without stall");
endmodule

FILE: rtl/core/mwcs_back.sv
module mwcs_back import mwcs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cmd_type           q_cmd,
   output logic              q_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [ADDR_W-1:0] rsp_window_start,
   output logic [POS_W-1:0]  rsp_window_length
);
   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [POS_W-1:0]  left_ff, left_in, right_ff, right_in;
   logic [DIST_W-1:0] dneed_ff, dneed_in, dmet_ff, dmet_in;
   logic [POS_W-1:0]  best_len_ff, best_len_in;
   logic [ADDR_W-1:0] best_st_ff, best_st_in;
   logic              ovf_ff, ovf_in;
   logic [PLEN_W-1:0] plen_ff, plen_in;
   logic [SYM_W-1:0]  clr_ff, clr_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic              rv_ff, rv_in;
   logic [1:0]        rs_ff, rs_in;
   logic [ADDR_W-1:0] rst_ff, rst_in;
   logic [POS_W-1:0]  rl_ff, rl_in;

   logic [NEED_W-1:0] need_rd, need_wd;
   logic [WCNT_W-1:0] wc_rd, wc_wd;
   logic [SYM_W-1:0]  txt_rd;
   logic              need_we, wc_we, txt_we;
   logic [SYM_W-1:0]  tab_ra, tab_wa;
   logic [ADDR_W-1:0] txt_ra;
   logic [POS_W-1:0]  wlen;

   mwcs_ram #(.WIDTH(NEED_W), .DEPTH(NSYM)) u_need (.clock, .wr_en(need_we),
      .wr_addr(tab_wa), .wr_data(need_wd), .rd_addr(tab_ra), .rd_data(need_rd));
   mwcs_ram #(.WIDTH(WCNT_W), .DEPTH(NSYM)) u_wcnt (.clock, .wr_en(wc_we),
      .wr_addr(tab_wa), .wr_data(wc_wd), .rd_addr(tab_ra), .rd_data(wc_rd));
   mwcs_ram #(.WIDTH(SYM_W), .DEPTH(TEXT_DEPTH)) u_text (.clock, .wr_en(txt_we),
      .wr_addr(right_ff[ADDR_W-1:0]), .wr_data(cmd_ff.symbol), .rd_addr(txt_ra),
      .rd_data(txt_rd));

   assign rsp_valid         = rv_ff;
   assign rsp_status        = rs_ff;
   assign rsp_window_start  = rst_ff;
   assign rsp_window_length = rl_ff;
   assign wlen = right_ff - left_ff + 1'b1;

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      sym_ff <= sym_in;
      rs_ff  <= rs_in;
      rst_ff <= rst_in;
      rl_ff  <= rl_in;
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         left_ff     <= '0;
         right_ff    <= '0;
         dneed_ff    <= '0;
         dmet_ff     <= '0;
         best_len_ff <= '1;
         best_st_ff  <= '0;
         ovf_ff      <= 1'b0;
         plen_ff     <= '0;
         rv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         left_ff     <= left_in;
         right_ff    <= right_in;
         dneed_ff    <= dneed_in;
         dmet_ff     <= dmet_in;
         best_len_ff <= best_len_in;
         best_st_ff  <= best_st_in;
         ovf_ff      <= ovf_in;
         plen_ff     <= plen_in;
         rv_ff       <= rv_in;
      end
   end

   // sequencer: at most one table read-modify-write per step
   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; sym_in = sym_ff;
      left_in = left_ff; right_in = right_ff; dneed_in = dneed_ff; dmet_in = dmet_ff;
      best_len_in = best_len_ff; best_st_in = best_st_ff; ovf_in = ovf_ff;
      plen_in = plen_ff; clr_in = clr_ff;
      rv_in = rv_ff & rsp_stall; rs_in = rs_ff; rst_in = rst_ff; rl_in = rl_ff;
      q_take = 1'b0; need_we = 1'b0; wc_we = 1'b0; txt_we = 1'b0;
      tab_ra = cmd_ff.symbol; tab_wa = cmd_ff.symbol;
      need_wd = need_rd + 1'b1; wc_wd = wc_rd + 1'b1;
      txt_ra = left_ff[ADDR_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            tab_ra = q_cmd.symbol;
            if (q_valid) begin
               q_take = 1'b1;
               cmd_in = q_cmd;
               if (q_cmd.op == OP_PATTERN) begin
                  if (right_ff != '0 || ovf_ff) state_in = ST_IDLE;
                  else if (plen_ff >= PLEN_W'(PATTERN_MAX)) ovf_in = 1'b1;
                  else state_in = ST_PAT_WR;
               end else if (ovf_ff) begin
                  state_in = q_cmd.last ? ST_REPORT : ST_IDLE;
               end else if (right_ff >= POS_W'(TEXT_DEPTH)) begin
                  ovf_in = 1'b1;
                  state_in = q_cmd.last ? ST_REPORT : ST_IDLE;
               end else begin
                  state_in = ST_TXT_WR;
               end
            end
         end
         ST_PAT_WR: begin
            need_we = 1'b1;
            plen_in = plen_ff + 1'b1;
            if (need_rd == '0) dneed_in = dneed_ff + 1'b1;
            state_in = ST_IDLE;
         end
         ST_TXT_WR: begin
            wc_we = 1'b1; txt_we = 1'b1;
            if (need_rd != '0 && wc_wd == WCNT_W'(need_rd)) dmet_in = dmet_ff + 1'b1;
            state_in = ST_LOOP;
         end
         ST_LOOP: begin
            if (dneed_ff != '0 && left_ff <= right_ff && dmet_ff == dneed_ff) begin
               if (wlen < best_len_ff) begin
                  best_len_in = wlen;
                  best_st_in = left_ff[ADDR_W-1:0];
               end
               state_in = ST_SHR_RD;
            end else begin
               right_in = right_ff + 1'b1;
               state_in = cmd_ff.last ? ST_REPORT : ST_IDLE;
            end
         end
         ST_SHR_RD: begin
            sym_in = txt_rd;
            tab_ra = txt_rd;
            state_in = ST_SHR_WR;
         end
         ST_SHR_WR: begin
            tab_wa = sym_ff;
            wc_we = 1'b1;
            wc_wd = wc_rd - 1'b1;
            if (need_rd != '0 && wc_wd < WCNT_W'(need_rd)) dmet_in = dmet_ff - 1'b1;
            left_in = left_ff + 1'b1;
            txt_ra = left_in[ADDR_W-1:0];
            state_in = ST_LOOP;
         end
         ST_REPORT: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               if (ovf_ff) begin
                  rs_in = STATUS_OVERFLOW; rst_in = '0; rl_in = '0;
               end else if (dneed_ff == '0 || best_len_ff == '1) begin
                  rs_in = STATUS_NONE; rst_in = '0; rl_in = '0;
               end else begin
                  rs_in = STATUS_FOUND; rst_in = best_st_ff; rl_in = best_len_ff;
               end
               clr_in = '0;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            tab_wa = clr_ff;
            need_we = 1'b1; wc_we = 1'b1; need_wd = '0; wc_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SYM_W'(NSYM - 1)) begin
               left_in = '0; right_in = '0; dneed_in = '0; dmet_in = '0;
               best_len_in = '1; best_st_in = '0; ovf_in = 1'b0; plen_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_met_le_need: assert property (@(posedge clock) disable iff (reset)
      dmet_ff <= dneed_ff) else $error("met exceeds needed");
   a_left_le_right: assert property (@(posedge clock) disable iff (reset)
      left_ff <= right_ff + 1'b1) else $error("left edge passed right");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |-> state_ff == ST_IDLE) else $error("take outside idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> rv_ff && $stable(rs_ff) && $stable(rl_ff))
      else $error("stalled item changed");
endmodule
